// ----- sv/lpcp_pkg.sv -----
// Shared constants, types and register codes for the lidar point projection block.
`timescale 1ns / 1ps
`default_nettype none

package lpcp_pkg;

  localparam int IMAGE_WIDTH_DEF  = 1280;
  localparam int IMAGE_HEIGHT_DEF = 720;

  localparam int COORD_BITS  = 12;
  localparam int SQRT_STAGES = 32;
  localparam int COLOR_BITS  = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_SHIFT_X   = 3'd4,
    REG_SHIFT_Y   = 3'd5,
    REG_SHIFT_Z   = 3'd6,
    REG_MAX_DEPTH = 3'd7
  } reg_index_t;

  localparam logic [27:0]        FOCAL_X_RST   = 28'd59487316;
  localparam logic [27:0]        FOCAL_Y_RST   = 28'd59459576;
  localparam logic [27:0]        CENTER_X_RST  = 28'd41550244;
  localparam logic [27:0]        CENTER_Y_RST  = 28'd23559412;
  localparam logic signed [31:0] SHIFT_X_RST   = -32'sd7930;
  localparam logic signed [31:0] SHIFT_Y_RST   = -32'sd2163;
  localparam logic signed [31:0] SHIFT_Z_RST   = -32'sd8323;
  localparam logic [30:0]        MAX_DEPTH_RST = 31'd196608;

  // Rotation Rz * Ry * Rx in Q2.30
  localparam logic signed [31:0] ROT [3][3] = '{
    '{ -32'sd3388355,   -32'sd1073713543,  32'sd7017940  },
    '{  32'sd759209812, -32'sd7358459,    -32'sd759254779 },
    '{  32'sd759282876,  32'sd2566226,     32'sd759213036 }
  };

  localparam logic signed [63:0] ROUND_HALF = 64'sd536870912;

  typedef struct packed {
    logic                  ok;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } pix_t;

  typedef struct packed {
    logic        show;
    logic        far;
    logic [10:0] col;
    logic [9:0]  row;
  } color_tag_t;

endpackage

`default_nettype wire

// ----- sv/lpcp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
`timescale 1ns / 1ps
`default_nettype none

module lpcp_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 50,
  parameter int Q_W   = 12,
  parameter int TAG_W = 2
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic [Q_W-1:0]   quot,
  output logic             rem_nz,
  output logic [TAG_W-1:0] tag_out
);

  localparam int IW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [IW-1:0]    rem_s  [1:Q_W];
  logic [IW-1:0]    den_s  [1:Q_W];
  logic [Q_W-1:0]   quot_s [1:Q_W];
  logic [TAG_W-1:0] tag_s  [1:Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam logic [Q_W-1:0] QBIT = Q_W'(1) << (Q_W - 1 - s);
    logic [IW-1:0]    rem_i;
    logic [IW-1:0]    den_i;
    logic [Q_W-1:0]   quot_i;
    logic [TAG_W-1:0] tag_i;
    logic [IW-1:0]    trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_i  = IW'(num);
      assign den_i  = IW'(den);
      assign quot_i = '0;
      assign tag_i  = tag_in;
    end else begin : g_next
      assign rem_i  = rem_s[s];
      assign den_i  = den_s[s];
      assign quot_i = quot_s[s];
      assign tag_i  = tag_s[s];
    end

    assign trial = den_i << (Q_W - 1 - s);
    assign ge    = rem_i >= trial;

    always_ff @(posedge clk) begin
      rem_s[s+1]  <= ge ? rem_i - trial : rem_i;
      quot_s[s+1] <= ge ? (quot_i | QBIT) : quot_i;
      den_s[s+1]  <= den_i;
      tag_s[s+1]  <= tag_i;
    end
  end

  assign quot    = quot_s[Q_W];
  assign rem_nz  = |rem_s[Q_W];
  assign tag_out = tag_s[Q_W];

endmodule

`default_nettype wire

// ----- sv/lpcp_sqrt.sv -----
// Pipelined integer square root of a 64-bit word, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lpcp_sqrt
  import lpcp_pkg::*;
#(
  parameter int TAG_W = 2
) (
  input  logic                     clk,
  input  logic [2*SQRT_STAGES-1:0] radicand,
  input  logic [TAG_W-1:0]         tag_in,
  output logic [SQRT_STAGES-1:0]   root,
  output logic [TAG_W-1:0]         tag_out
);

  localparam int SW = 2 * SQRT_STAGES;

  logic [SW-1:0]    n_s    [1:SQRT_STAGES];
  logic [SW-1:0]    root_s [1:SQRT_STAGES];
  logic [TAG_W-1:0] tag_s  [1:SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * s);
    logic [SW-1:0]    n_i;
    logic [SW-1:0]    root_i;
    logic [TAG_W-1:0] tag_i;
    logic [SW-1:0]    trial;

    if (s == 0) begin : g_first
      assign n_i    = radicand;
      assign root_i = '0;
      assign tag_i  = tag_in;
    end else begin : g_next
      assign n_i    = n_s[s];
      assign root_i = root_s[s];
      assign tag_i  = tag_s[s];
    end

    assign trial = root_i + BIT;

    always_ff @(posedge clk) begin
      if (n_i >= trial) begin
        n_s[s+1]    <= n_i - trial;
        root_s[s+1] <= (root_i >> 1) + BIT;
      end else begin
        n_s[s+1]    <= n_i;
        root_s[s+1] <= root_i >> 1;
      end
      tag_s[s+1] <= tag_i;
    end
  end

  assign root    = root_s[SQRT_STAGES][SQRT_STAGES-1:0];
  assign tag_out = tag_s[SQRT_STAGES];

endmodule

`default_nettype wire

// ----- sv/lidar_point_camera_projection.sv -----
// Lidar point to camera pixel projection with depth colour, top level.
// Path from start to done: 4 front stages, 32 square-root stages, colour prep,
// 8 colour divider stages and the output register; the square root sets its length.
// Throughput: one point per cycle; busy stays low and every point yields one word on done.
// Reset: restores the configuration registers and clears all pipeline valid bits.
`timescale 1ns / 1ps
`default_nettype none

module lidar_point_camera_projection
  import lpcp_pkg::*;
#(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [31:0]     point_x,
  input  logic signed [31:0]     point_y,
  input  logic signed [31:0]     point_z,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   done,
  output logic                   visible,
  output logic [10:0]            pixel_col,
  output logic [9:0]             pixel_row,
  output logic [7:0]             blue_level,
  output logic [7:0]             red_level
);

  localparam int LAT      = 6 + SQRT_STAGES + COLOR_BITS;
  localparam int UV_LAST  = SQRT_STAGES - COORD_BITS - 2;
  localparam int DEN_W    = 50;

  logic [27:0]        focal_x, focal_y, center_x, center_y;
  logic signed [31:0] shift_r [3];
  logic [30:0]        max_depth;
  logic [LAT-1:0]     vld;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x    <= FOCAL_X_RST;
      focal_y    <= FOCAL_Y_RST;
      center_x   <= CENTER_X_RST;
      center_y   <= CENTER_Y_RST;
      shift_r[0] <= SHIFT_X_RST;
      shift_r[1] <= SHIFT_Y_RST;
      shift_r[2] <= SHIFT_Z_RST;
      max_depth  <= MAX_DEPTH_RST;
      vld        <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
      if (cfg_write) begin
        unique case (reg_index_t'(cfg_index))
          REG_FOCAL_X:   focal_x    <= cfg_data[27:0];
          REG_FOCAL_Y:   focal_y    <= cfg_data[27:0];
          REG_CENTER_X:  center_x   <= cfg_data[27:0];
          REG_CENTER_Y:  center_y   <= cfg_data[27:0];
          REG_SHIFT_X:   shift_r[0] <= signed'(cfg_data);
          REG_SHIFT_Y:   shift_r[1] <= signed'(cfg_data);
          REG_SHIFT_Z:   shift_r[2] <= signed'(cfg_data);
          REG_MAX_DEPTH: max_depth  <= cfg_data[30:0];
        endcase
      end
    end
  end

  assign done = vld[LAT-1];

  // stage 1: rotation products
  logic signed [31:0] pt [3];
  logic signed [63:0] prod [3][3];

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod[i][k] <= ROT[i][k] * pt[k];
      end
    end
  end

  // stage 2: round to Q16.16 and translate
  logic signed [63:0] acc [3];
  logic signed [34:0] cam [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = prod[i][0] + prod[i][1] + prod[i][2] + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      cam[i] <= 35'(signed'(acc[i][63:30])) + 35'(shift_r[i]);
    end
  end

  // stage 3: projection products, squares, flags
  logic [34:0]        mag [3];
  logic signed [63:0] pfx, pcx, pfy, pcy;
  logic [61:0]        sq [3];
  logic               front3, far3;
  logic [33:0]        dz3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = cam[i][34] ? 35'(-cam[i]) : 35'(cam[i]);
    end
  end

  always_ff @(posedge clk) begin
    pfx <= signed'({1'b0, focal_x}) * cam[0];
    pcx <= signed'({1'b0, center_x}) * cam[2];
    pfy <= signed'({1'b0, focal_y}) * cam[1];
    pcy <= signed'({1'b0, center_y}) * cam[2];
    for (int i = 0; i < 3; i++) begin
      sq[i] <= 62'(mag[i][30:0]) * 62'(mag[i][30:0]);
    end
    front3 <= cam[2] > 35'sd0;
    far3   <= (|mag[0][34:31]) | (|mag[1][34:31]) | (|mag[2][34:31]);
    dz3    <= cam[2][33:0];
  end

  // stage 4: numerators, denominator, squared depth
  logic signed [63:0] nu4, nv4;
  logic [DEN_W-1:0]   den4;
  logic [63:0]        sumsq4;
  logic               front4, far4;

  always_ff @(posedge clk) begin
    nu4    <= pfx + pcx;
    nv4    <= pfy + pcy;
    den4   <= {dz3, 16'b0};
    sumsq4 <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
    front4 <= front3;
    far4   <= far3;
  end

  // stage 5: magnitudes and range check
  logic [63:0]      au5, av5, lim4;
  logic [DEN_W-1:0] den5;
  logic             negu5, negv5, badu5, badv5;

  assign lim4 = 64'(den4) << COORD_BITS;

  always_ff @(posedge clk) begin
    au5   <= nu4[63] ? 64'(-nu4) : 64'(nu4);
    av5   <= nv4[63] ? 64'(-nv4) : 64'(nv4);
    negu5 <= nu4[63];
    negv5 <= nv4[63];
    badu5 <= (nu4[63] ? 64'(-nu4) : 64'(nu4)) >= lim4;
    badv5 <= (nv4[63] ? 64'(-nv4) : 64'(nv4)) >= lim4;
    den5  <= den4;
  end

  logic [COORD_BITS-1:0] qu, qv;
  logic [1:0]            tu, tv;
  logic                  ru_nz, rv_nz;

  lpcp_div #(
    .NUM_W(64), .DEN_W(DEN_W), .Q_W(COORD_BITS), .TAG_W(2)
  ) u_div_col (
    .clk(clk), .num(au5), .den(den5), .tag_in({negu5, badu5}),
    .quot(qu), .rem_nz(ru_nz), .tag_out(tu)
  );

  lpcp_div #(
    .NUM_W(64), .DEN_W(DEN_W), .Q_W(COORD_BITS), .TAG_W(2)
  ) u_div_row (
    .clk(clk), .num(av5), .den(den5), .tag_in({negv5, badv5}),
    .quot(qv), .rem_nz(rv_nz), .tag_out(tv)
  );

  logic ok_u, ok_v;
  pix_t uv_dly [0:UV_LAST];

  assign ok_u = !tu[0] && (tu[1] ? (qu == '0)
                : ({1'b0, qu} < (COORD_BITS + 1)'(IMAGE_WIDTH)));
  assign ok_v = !tv[0] && (tv[1] ? (qv == '0)
                : ({1'b0, qv} < (COORD_BITS + 1)'(IMAGE_HEIGHT)));

  always_ff @(posedge clk) begin
    uv_dly[0].ok  <= ok_u && ok_v;
    uv_dly[0].col <= qu;
    uv_dly[0].row <= qv;
    for (int j = 1; j <= UV_LAST; j++) begin
      uv_dly[j] <= uv_dly[j-1];
    end
  end

  // depth
  logic [SQRT_STAGES-1:0] depth;
  logic [1:0]             sq_tag;

  lpcp_sqrt #(.TAG_W(2)) u_sqrt (
    .clk(clk), .radicand(sumsq4), .tag_in({front4, far4}),
    .root(depth), .tag_out(sq_tag)
  );

  // colour prep
  logic [30:0]       md_eff;
  logic [39:0]       cnum;
  logic [30:0]       cden;
  color_tag_t        ctag;

  assign md_eff = (max_depth == '0) ? 31'd1 : max_depth;

  always_ff @(posedge clk) begin
    cnum      <= (40'(depth) << 8) - 40'(depth);
    cden      <= md_eff;
    ctag.show <= sq_tag[1] && uv_dly[UV_LAST].ok;
    ctag.far  <= sq_tag[0] || (depth > 32'(md_eff));
    ctag.col  <= uv_dly[UV_LAST].col[10:0];
    ctag.row  <= uv_dly[UV_LAST].row[9:0];
  end

  logic [COLOR_BITS-1:0] cq;
  logic                  c_nz;
  color_tag_t            cto;

  lpcp_div #(
    .NUM_W(40), .DEN_W(31), .Q_W(COLOR_BITS), .TAG_W($bits(color_tag_t))
  ) u_div_color (
    .clk(clk), .num(cnum), .den(cden), .tag_in(ctag),
    .quot(cq), .rem_nz(c_nz), .tag_out(cto)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!cto.show) begin
      visible    <= 1'b0;
      pixel_col  <= '0;
      pixel_row  <= '0;
      blue_level <= '0;
      red_level  <= '0;
    end else begin
      visible   <= 1'b1;
      pixel_col <= cto.col;
      pixel_row <= cto.row;
      if (cto.far) begin
        red_level  <= 8'd255;
        blue_level <= 8'd0;
      end else begin
        red_level  <= cq;
        blue_level <= 8'd255 - cq - 8'(c_nz);
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/lidar_point_camera_projection_tb.sv -----
// Self-checking testbench for the lidar point camera projection block.
`timescale 1ns / 1ps
`default_nettype none

module lidar_point_camera_projection_tb;
  import lpcp_pkg::*;

  localparam int WIDTH_PX  = 1280;
  localparam int HEIGHT_PX = 720;
  localparam int LATENCY   = 46;
  localparam int WATCHDOG  = 4000;
  localparam int N_RANDOM  = 1750;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } point_t;

  typedef struct {
    logic        vis;
    logic [10:0] col;
    logic [9:0]  row;
    logic [7:0]  blue;
    logic [7:0]  red;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic done, visible;
  logic [10:0] pixel_col;
  logic [9:0] pixel_row;
  logic [7:0] blue_level, red_level;

  lidar_point_camera_projection uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .visible(visible), .pixel_col(pixel_col), .pixel_row(pixel_row),
    .blue_level(blue_level), .red_level(red_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [27:0] fx, fy, cx, cy;
  logic signed [31:0] sx, sy, sz;
  logic [30:0] mdepth;

  point_t      point_queue[$];
  pixel_word_t pixel_queue[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  timed_out = 0;
  bit  hold_sender = 0;
  bit  calm = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root, bit_v, rem;
    root = 0;
    bit_v = 64'd1 << 62;
    rem = n;
    while (bit_v > rem) bit_v >>= 2;
    while (bit_v != 0) begin
      if (rem >= root + bit_v) begin
        rem -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic pixel_word_t project_point(input point_t p);
    pixel_word_t w;
    logic signed [63:0] rot [3][3];
    logic signed [63:0] pin[3], cam[3], shv[3], acc, u, v, den;
    logic [63:0] md, d, ax, ay, az, r, b;
    rot = '{'{-64'sd3388355, -64'sd1073713543, 64'sd7017940},
            '{64'sd759209812, -64'sd7358459, -64'sd759254779},
            '{64'sd759282876, 64'sd2566226, 64'sd759213036}};
    pin[0] = 64'(p.px); pin[1] = 64'(p.py); pin[2] = 64'(p.pz);
    shv[0] = 64'(sx); shv[1] = 64'(sy); shv[2] = 64'(sz);
    w = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += rot[i][k] * pin[k];
      acc += 64'sd536870912;
      cam[i] = (acc >>> 30) + shv[i];
    end
    if (cam[2] <= 0) return w;
    den = cam[2] * 64'sd65536;
    u = ($signed({36'd0, fx}) * cam[0] + $signed({36'd0, cx}) * cam[2]) / den;
    v = ($signed({36'd0, fy}) * cam[1] + $signed({36'd0, cy}) * cam[2]) / den;
    if (u < 0 || u >= WIDTH_PX || v < 0 || v >= HEIGHT_PX) return w;
    md = (mdepth == 0) ? 64'd1 : {33'd0, mdepth};
    ax = cam[0] < 0 ? -cam[0] : cam[0];
    ay = cam[1] < 0 ? -cam[1] : cam[1];
    az = cam[2] < 0 ? -cam[2] : cam[2];
    if (ax >= 64'd1 << 31 || ay >= 64'd1 << 31 || az >= 64'd1 << 31) begin
      r = 255; b = 0;
    end else begin
      d = int_sqrt(ax * ax + ay * ay + az * az);
      if (d > md) begin
        r = 255; b = 0;
      end else begin
        r = (64'd255 * d) / md;
        b = (64'd255 * (md - d)) / md;
        if (r > 255) r = 255;
        if (b > 255) b = 255;
      end
    end
    w.vis = 1'b1;
    w.col = u[10:0];
    w.row = v[9:0];
    w.blue = b[7:0];
    w.red = r[7:0];
    return w;
  endfunction

  // driver: advance one word per accepted start
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pixel_queue.push_back(project_point('{point_x, point_y, point_z}));
        void'(point_queue.pop_front());
      end
      if (!hold_sender && point_queue.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
        start <= 1'b1;
        point_x <= point_queue[0].px;
        point_y <= point_queue[0].py;
        point_z <= point_queue[0].pz;
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_word_t e;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (pixel_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word at %0t", $realtime);
        end else begin
          e = pixel_queue.pop_front();
          if (visible !== e.vis || pixel_col !== e.col || pixel_row !== e.row ||
              blue_level !== e.blue || red_level !== e.red) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                       e.vis, e.col, e.row, e.blue, e.red, visible, pixel_col,
                       pixel_row, blue_level, red_level);
          end
        end
      end
      if (idle_cycles >= WATCHDOG) timed_out = 1;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_FOCAL_X:   fx = val[27:0];
      REG_FOCAL_Y:   fy = val[27:0];
      REG_CENTER_X:  cx = val[27:0];
      REG_CENTER_Y:  cy = val[27:0];
      REG_SHIFT_X:   sx = val;
      REG_SHIFT_Y:   sy = val;
      REG_SHIFT_Z:   sz = val;
      REG_MAX_DEPTH: mdepth = val[30:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while ((point_queue.size() > 0 || pixel_queue.size() > 0 || start) && !timed_out)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(input int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed($urandom_range(2000000)) - 1000000;
      default: return $signed($urandom_range(400000)) - 200000;
    endcase
  endfunction

  task automatic add_random(input int n);
    point_t p;
    int m;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(9);
      m = (m == 0) ? 0 : (m < 4 ? 1 : 2);
      // mostly points in front of the camera (lidar forward is +x)
      p.px = (m == 0) ? $signed($urandom()) : $signed($urandom_range(1500000, 20000));
      p.py = rand_coord(m);
      p.pz = rand_coord(m);
      point_queue.push_back(p);
    end
  endtask

  initial begin
    fx = FOCAL_X_RST; fy = FOCAL_Y_RST; cx = CENTER_X_RST; cy = CENTER_Y_RST;
    sx = SHIFT_X_RST; sy = SHIFT_Y_RST; sz = SHIFT_Z_RST; mdepth = MAX_DEPTH_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    point_queue.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
    point_queue.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000});
    point_queue.push_back('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF});
    point_queue.push_back('{0, 0, 0});
    point_queue.push_back('{-32'sd1, -32'sd1, -32'sd1});
    point_queue.push_back('{32'sd131072, 0, 0});
    point_queue.push_back('{32'sd65536, 0, 0});
    point_queue.push_back('{32'sd131072, 32'sd60000, 32'sd40000});
    point_queue.push_back('{32'sd131072, -32'sd60000, -32'sd40000});
    point_queue.push_back('{-32'sd131072, 0, 0});
    point_queue.push_back('{32'sd1000000, 0, 0});
    point_queue.push_back('{32'sd300000, 32'sd1, -32'sd1});
    point_queue.push_back('{32'sd8323, 0, 0});
    point_queue.push_back('{32'sh40000000, 0, 0});
    drain();

    write_reg(REG_MAX_DEPTH, 32'd0);
    write_reg(REG_SHIFT_X, 32'h7FFFFFFF);
    write_reg(REG_SHIFT_Z, 32'h80000000);
    add_random(40);
    drain();

    write_reg(REG_SHIFT_Z, 32'h7FFFFFFF);
    write_reg(REG_SHIFT_X, 32'h80000000);
    write_reg(REG_SHIFT_Y, 32'h7FFFFFFF);
    write_reg(REG_MAX_DEPTH, 32'h7FFFFFFF);
    add_random(40);
    drain();

    write_reg(REG_FOCAL_X, 32'hFFFFFFFF);
    write_reg(REG_FOCAL_Y, 32'h0);
    write_reg(REG_CENTER_X, 32'h0);
    write_reg(REG_CENTER_Y, 32'hFFFFFFFF);
    write_reg(REG_SHIFT_X, 32'd0);
    write_reg(REG_SHIFT_Y, 32'h80000000);
    write_reg(REG_SHIFT_Z, 32'd0);
    add_random(40);
    drain();

    write_reg(REG_FOCAL_X, 32'(FOCAL_X_RST));
    write_reg(REG_FOCAL_Y, 32'(FOCAL_Y_RST));
    write_reg(REG_CENTER_X, 32'(CENTER_X_RST));
    write_reg(REG_CENTER_Y, 32'(CENTER_Y_RST));
    write_reg(REG_SHIFT_X, SHIFT_X_RST);
    write_reg(REG_SHIFT_Y, SHIFT_Y_RST);
    write_reg(REG_SHIFT_Z, SHIFT_Z_RST);
    write_reg(REG_MAX_DEPTH, 32'd65536);
    calm = 1;
    add_random(400);
    drain();
    calm = 0;

    // hold the sender until the pipeline empties
    add_random(300);
    repeat (20) @(posedge clk);
    hold_sender = 1;
    while (pixel_queue.size() > 0 && !timed_out) @(posedge clk);
    hold_sender = 0;
    drain();

    write_reg(REG_MAX_DEPTH, 32'(MAX_DEPTH_RST));
    add_random(N_RANDOM - 820);
    drain();

    if (timed_out) begin
      $display("lidar_point_camera_projection verification failed");
    end else if (mismatches == 0 && pixel_queue.size() == 0) begin
      $display("lidar_point_camera_projection verification clean");
    end else begin
      $display("lidar_point_camera_projection verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
sv/lpcp_pkg.sv
sv/lpcp_div.sv
sv/lpcp_sqrt.sv
sv/lidar_point_camera_projection.sv
tb/lidar_point_camera_projection_tb.sv
